@@ rtl/core/vsc_pkg.sv @@
// ----------------------------------------------------------------------------
// vsc_pkg: shared types and constants of the versioned slot cache
// Command and status codes, queue entry and result layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package vsc_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 64;
  localparam int unsigned TAG_BITS_DEF  = 16;
  localparam int unsigned VER_W         = 63;
  localparam int unsigned REF_W         = 16;
  localparam int unsigned IO_TAG_W      = 16;
  localparam int unsigned SLOT_W        = 6;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // largest signed 64-bit value, also the start distance of a nearest search
  localparam logic [VER_W-1:0] VER_MAX = '1;

  typedef enum logic [2:0] {
    CMD_GET       = 3'd0,
    CMD_NEAREST   = 3'd1,
    CMD_RELEASE   = 3'd2,
    CMD_PUT       = 3'd3,
    CMD_GC        = 3'd4,
    CMD_ELIMINATE = 3'd5,
    CMD_RECYCLE   = 3'd6,
    CMD_EXISTS    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RETRY     = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_BASE_SLOTS   = 2'd0,
    REG_TENANT_LIMIT = 2'd1,
    REG_ALLOW_GROWTH = 2'd2
  } reg_idx_e;

  typedef struct packed {
    cmd_e                command;
    logic [VER_W-1:0]    version;
    logic [IO_TAG_W-1:0] tag;
    logic [SLOT_W-1:0]   slot_index;
    logic                take_ref;
    logic                slot_bad;   // release index beyond the table
  } cmd_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   hit_slot;
    logic [VER_W-1:0]    version;
    logic [IO_TAG_W-1:0] tag;
    logic                tag_valid;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/vsc_ram.sv @@
// ----------------------------------------------------------------------------
// vsc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/vsc_front.sv @@
// ----------------------------------------------------------------------------
// vsc_front: command intake
// Unpacks stream transfers, flags bad release indexes, queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_front #(
  parameter int unsigned MAX_SLOTS = vsc_pkg::MAX_SLOTS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [87:0]   in_data_i,
  input  wire logic [2:0]    in_user_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output vsc_pkg::cmd_t      cmd_o
);
  import vsc_pkg::*;

  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              q_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  cmd_t              in_cmd;
  logic              push, pop;

  always_comb begin
    in_cmd.command    = cmd_e'(in_user_i);
    in_cmd.version    = in_data_i[62:0];
    in_cmd.tag        = in_data_i[78:63];
    in_cmd.slot_index = in_data_i[84:79];
    in_cmd.take_ref   = in_data_i[85];
    in_cmd.slot_bad   = (32'(in_data_i[84:79]) >= MAX_SLOTS);
  end

  assign in_ready_o  = (32'(cnt_q) != QUEUE_DEPTH);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? QPTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? QPTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/vsc_back.sv @@
// ----------------------------------------------------------------------------
// vsc_back: command execution
// Slot table, scan sequencer, newest-slot tracking and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_back #(
  parameter int unsigned MAX_SLOTS = vsc_pkg::MAX_SLOTS_DEF,
  parameter int unsigned TAG_BITS  = vsc_pkg::TAG_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [6:0]    cfg_base_i,
  input  wire logic [6:0]    cfg_tenant_i,
  input  wire logic          cfg_allow_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire vsc_pkg::cmd_t cmd_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output vsc_pkg::res_t      res_o
);
  import vsc_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned WORD_W = VER_W + TAG_BITS + REF_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  typedef enum logic [3:0] {
    K_NEWCHK, K_EXACT, K_NEAR, K_REL, K_PUT, K_CLR, K_RECY, K_RECYN, K_NEWEST
  } kind_e;

  state_e                state_q, state_d;
  kind_e                 kind_q, kind_d;
  cmd_t                  cmd_q, cmd_d;
  logic [IDX_W-1:0]      rd_ptr_q, rd_ptr_d, d_idx_q, d_idx_d;
  logic [CNT_W-1:0]      rd_left_q, rd_left_d;
  logic                  d_vld_q, d_vld_d;
  logic                  found_q, found_d, hit_ev_q, hit_ev_d;
  logic [IDX_W-1:0]      hit_idx_q, hit_idx_d;
  logic [VER_W-1:0]      hit_ver_q, hit_ver_d, best_q, best_d;
  logic [TAG_BITS-1:0]   hit_tag_q, hit_tag_d;
  logic [REF_W-1:0]      hit_refs_q, hit_refs_d;
  logic                  nb_have_q, nb_have_d;
  logic [IDX_W-1:0]      nb_idx_q, nb_idx_d;
  logic [VER_W-1:0]      nb_ver_q, nb_ver_d;
  logic [MAX_SLOTS-1:0]  valid_q, valid_d;
  logic [CNT_W-1:0]      grown_q, grown_d;
  logic [IDX_W-1:0]      hint_q, hint_d, newest_q, newest_d;
  res_t                  pend_q, pend_d, out_q;
  logic                  out_vld_q, out_vld_d, out_load;

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;

  logic [CNT_W-1:0]      base_c, n_act, lim, n_put, ptr_inc;
  logic                  e_valid, rec, stop, nb_rec;
  logic [VER_W-1:0]      e_ver, e_dist;
  logic [TAG_BITS-1:0]   e_tag;
  logic [REF_W-1:0]      e_refs, refs_inc;
  logic                  start;
  kind_e                 st_kind;
  logic [IDX_W-1:0]      st_ptr;
  logic [CNT_W-1:0]      st_len;

  vsc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // active slot count, put growth target and next read pointer
  always_comb begin
    if (cfg_base_i == '0) begin
      base_c = CNT_W'(1);
    end else if (32'(cfg_base_i) > MAX_SLOTS) begin
      base_c = CNT_W'(MAX_SLOTS);
    end else begin
      base_c = CNT_W'(cfg_base_i);
    end
    n_act   = (grown_q > base_c) ? grown_q : base_c;
    lim     = (32'(cfg_tenant_i) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(cfg_tenant_i);
    n_put   = (lim > n_act) ? lim : n_act;
    ptr_inc = CNT_W'(rd_ptr_q) + CNT_W'(1);
  end

  // entry under evaluation
  always_comb begin
    e_valid  = valid_q[d_idx_q];
    e_ver    = ram_rdata[VER_W-1:0];
    e_tag    = ram_rdata[VER_W +: TAG_BITS];
    e_refs   = e_valid ? ram_rdata[VER_W+TAG_BITS +: REF_W] : '0;
    e_dist   = (e_ver >= cmd_q.version) ? (e_ver - cmd_q.version) : (cmd_q.version - e_ver);
    refs_inc = (hit_refs_q != '1) ? (hit_refs_q + REF_W'(1)) : hit_refs_q;
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cmd_d      = cmd_q;
    rd_ptr_d   = rd_ptr_q;
    rd_left_d  = rd_left_q;
    d_vld_d    = 1'b0;
    d_idx_d    = d_idx_q;
    found_d    = found_q;
    hit_ev_d   = hit_ev_q;
    hit_idx_d  = hit_idx_q;
    hit_ver_d  = hit_ver_q;
    hit_tag_d  = hit_tag_q;
    hit_refs_d = hit_refs_q;
    best_d     = best_q;
    nb_have_d  = nb_have_q;
    nb_idx_d   = nb_idx_q;
    nb_ver_d   = nb_ver_q;
    valid_d    = valid_q;
    grown_d    = grown_q;
    hint_d     = hint_q;
    newest_d   = newest_q;
    pend_d     = pend_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = hit_idx_q;
    ram_wdata  = {hit_refs_q, hit_tag_q, hit_ver_q};
    rec        = 1'b0;
    stop       = 1'b0;
    nb_rec     = 1'b0;
    start      = 1'b0;
    st_kind    = kind_q;
    st_ptr     = '0;
    st_len     = n_act;
    out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          start = 1'b1;
          case (cmd_i.command)
            CMD_GET, CMD_EXISTS: begin
              st_kind = K_NEWCHK;
              st_ptr  = newest_q;
              st_len  = CNT_W'(1);
            end
            CMD_NEAREST: st_kind = K_NEAR;
            CMD_RELEASE: begin
              st_kind = K_REL;
              st_ptr  = IDX_W'(cmd_i.slot_index);
              st_len  = cmd_i.slot_bad ? '0 : CNT_W'(1);
            end
            CMD_PUT: begin
              st_kind = K_PUT;
              if (cfg_allow_i) begin
                grown_d = n_put;
                st_len  = n_put;
              end
            end
            CMD_GC, CMD_ELIMINATE: st_kind = K_CLR;
            CMD_RECYCLE:           st_kind = K_RECY;
            default:               st_kind = K_NEAR;
          endcase
        end
      end

      S_SCAN: begin
        if (d_vld_q) begin
          case (kind_q)
            K_NEWCHK, K_EXACT: begin
              rec  = e_valid && (e_ver == cmd_q.version);
              stop = rec;
            end
            K_NEAR: rec = e_valid && (e_dist < best_q);
            K_REL: begin
              rec  = 1'b1;
              stop = 1'b1;
            end
            K_PUT: begin
              if (!e_valid) begin
                rec  = 1'b1;
                stop = 1'b1;
              end else begin
                rec = (e_refs == '0) && (!found_q || (e_ver < hit_ver_q));
              end
            end
            K_CLR: begin
              rec  = e_valid && ((cmd_q.command == CMD_GC) ? (e_refs == '0)
                                 : (e_tag == TAG_BITS'(cmd_q.tag)));
              stop = rec;
            end
            K_RECY:  rec = e_valid && (e_refs != '0) && (!found_q || (e_ver < hit_ver_q));
            K_RECYN: rec = e_valid;
            K_NEWEST: nb_rec = e_valid && (!nb_have_q || (nb_ver_q < e_ver));
            default: rec = 1'b0;
          endcase
        end
        if (rec) begin
          found_d    = 1'b1;
          hit_ev_d   = e_valid;
          hit_idx_d  = d_idx_q;
          hit_ver_d  = e_ver;
          hit_tag_d  = e_tag;
          hit_refs_d = e_refs;
          best_d     = e_dist;
        end
        if (nb_rec) begin
          nb_have_d = 1'b1;
          nb_idx_d  = d_idx_q;
          nb_ver_d  = e_ver;
        end
        if ((rd_left_q != '0) && !stop) begin
          ram_re    = 1'b1;
          d_vld_d   = 1'b1;
          d_idx_d   = rd_ptr_q;
          rd_ptr_d  = (ptr_inc >= n_act) ? '0 : IDX_W'(ptr_inc);
          rd_left_d = rd_left_q - CNT_W'(1);
        end else if (stop || !d_vld_q) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        state_d = S_OUT;
        pend_d  = '{status: ST_NOT_FOUND, hit_slot: '0, version: '0, tag: '0,
                    tag_valid: 1'b0};
        case (kind_q)
          K_NEWCHK, K_EXACT, K_NEAR: begin
            if (found_q) begin
              if (kind_q != K_NEAR) begin
                hint_d = hit_idx_q;
              end
              if (cmd_q.command != CMD_EXISTS) begin
                ram_we    = 1'b1;
                ram_wdata = {refs_inc, hit_tag_q, hit_ver_q};
              end
              pend_d = '{status: ST_OK, hit_slot: SLOT_W'(hit_idx_q), version: hit_ver_q,
                         tag: IO_TAG_W'(hit_tag_q), tag_valid: 1'b1};
            end else if ((kind_q == K_NEWCHK) && (CNT_W'(hint_q) < n_act)) begin
              start   = 1'b1;
              st_kind = K_EXACT;
              st_ptr  = hint_q;
            end
          end
          K_REL: begin
            pend_d.hit_slot = cmd_q.slot_index;
            if (found_q && (hit_refs_q != '0)) begin
              ram_we          = 1'b1;
              ram_wdata       = {hit_refs_q - REF_W'(1), hit_tag_q, hit_ver_q};
              pend_d.status   = ST_OK;
            end else begin
              pend_d.status   = ST_INVALID;
            end
          end
          K_PUT: begin
            if (found_q) begin
              ram_we             = 1'b1;
              ram_wdata          = {REF_W'(cmd_q.take_ref), TAG_BITS'(cmd_q.tag),
                                    cmd_q.version};
              valid_d[hit_idx_q] = 1'b1;
              pend_d = '{status: ST_OK, hit_slot: SLOT_W'(hit_idx_q), version: cmd_q.version,
                         tag: hit_ev_q ? IO_TAG_W'(hit_tag_q) : '0, tag_valid: hit_ev_q};
              start   = 1'b1;
              st_kind = K_NEWEST;
            end else begin
              pend_d.status = ST_RETRY;
            end
          end
          K_CLR: begin
            if (found_q) begin
              pend_d = '{status: ST_OK, hit_slot: SLOT_W'(hit_idx_q), version: hit_ver_q,
                         tag: IO_TAG_W'(hit_tag_q), tag_valid: 1'b1};
              if (hit_refs_q != '0) begin
                pend_d.status = ST_RETRY;
              end else begin
                valid_d[hit_idx_q] = 1'b0;
                start              = 1'b1;
                st_kind            = K_NEWEST;
              end
            end
          end
          K_RECY, K_RECYN: begin
            if (found_q) begin
              pend_d = '{status: ST_OK, hit_slot: SLOT_W'(hit_idx_q), version: hit_ver_q,
                         tag: IO_TAG_W'(hit_tag_q), tag_valid: 1'b1};
            end else if (kind_q == K_RECY) begin
              start   = 1'b1;
              st_kind = K_RECYN;
              st_ptr  = newest_q;
              st_len  = CNT_W'(1);
            end
          end
          K_NEWEST: begin
            pend_d = pend_q;
            if (nb_have_q) begin
              newest_d = nb_idx_q;
            end
          end
          default: pend_d = pend_q;
        endcase
      end

      S_OUT: begin
        if (!out_vld_q || res_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (start) begin
      kind_d    = st_kind;
      rd_ptr_d  = st_ptr;
      rd_left_d = st_len;
      found_d   = 1'b0;
      nb_have_d = 1'b0;
      best_d    = VER_MAX;
      state_d   = S_SCAN;
    end

    out_vld_d = out_load ? 1'b1 : (res_ready_i ? 1'b0 : out_vld_q);
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      kind_q    <= K_NEWCHK;
      rd_left_q <= '0;
      d_vld_q   <= 1'b0;
      found_q   <= 1'b0;
      nb_have_q <= 1'b0;
      valid_q   <= '0;
      grown_q   <= '0;
      hint_q    <= '0;
      newest_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      rd_left_q <= rd_left_d;
      d_vld_q   <= d_vld_d;
      found_q   <= found_d;
      nb_have_q <= nb_have_d;
      valid_q   <= valid_d;
      grown_q   <= grown_d;
      hint_q    <= hint_d;
      newest_q  <= newest_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rd_ptr_q   <= rd_ptr_d;
    d_idx_q    <= d_idx_d;
    hit_ev_q   <= hit_ev_d;
    hit_idx_q  <= hit_idx_d;
    hit_ver_q  <= hit_ver_d;
    hit_tag_q  <= hit_tag_d;
    hit_refs_q <= hit_refs_d;
    best_q     <= best_d;
    nb_idx_q   <= nb_idx_d;
    nb_ver_q   <= nb_ver_d;
    pend_q     <= pend_d;
    if (out_load) begin
      out_q <= pend_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_write_in_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_FIN))
    else $error("slot table written outside the finish step");

  a_load_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q == S_IDLE))
    else $error("sequencer not idle after result load");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld_q |-> ($past(state_q) == S_SCAN))
    else $error("read data pending without a scan");

  a_hint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(hint_q) < MAX_SLOTS) && (32'(newest_q) < MAX_SLOTS))
    else $error("hint or newest index beyond table");
`endif

endmodule

`default_nettype wire

@@ rtl/core/versioned_slot_cache_with_refcount.sv @@
// ----------------------------------------------------------------------------
// versioned_slot_cache_with_refcount: versioned slot cache, top level
// Config registers, command intake queue and execution engine.
// ----------------------------------------------------------------------------
// A table of MAX_SLOTS slots, each with a valid mark, a 63-bit version, a tag
// and a 16-bit reference count, served by one command per input transfer and
// one result transfer per command. Version, tag and count live in a single
// RAM; the engine reads one slot per cycle. The active slot count is the
// larger of base_slots and the grown count. Get and exists that miss the
// newest slot rescan from the lookup hint, and recycle with no referenced
// slot checks the newest slot; put, gc and eliminate that change the table
// rescan for the newest slot. A two-entry queue in front keeps accepting
// commands while the engine works, and a result register lets the engine
// finish while the previous result waits to be taken. There is no clearing
// pass after reset: valid bits sit in flops, and a slot that is not valid
// reads as zero references.
// Config registers (APB, byte address 4*i): 0 base_slots, 1 tenant_slot_limit,
// 2 allow_growth. Write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module versioned_slot_cache_with_refcount #(
  parameter int unsigned MAX_SLOTS = vsc_pkg::MAX_SLOTS_DEF,
  parameter int unsigned TAG_BITS  = vsc_pkg::TAG_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [62:0] version_value, [78:63] entry_tag, [84:79] slot_index,
  // [85] take_reference, [87:86] zero
  input  wire logic [87:0] s_axis_tdata,
  // [2:0] command
  input  wire logic [2:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [5:0] hit_slot, [68:6] found_version, [84:69] out_tag, [85] tag_valid,
  // [87:86] zero
  output logic      [87:0] m_axis_tdata,
  // [1:0] status
  output logic      [1:0]  m_axis_tuser,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import vsc_pkg::*;

  logic [6:0] base_q, tenant_q;
  logic       allow_q;
  logic       cfg_wr;
  logic       cmd_valid, cmd_ready, res_valid;
  cmd_t       cmd;
  res_t       res;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= 7'd16;
      tenant_q <= 7'd0;
      allow_q  <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_BASE_SLOTS:   base_q   <= pwdata[6:0];
        REG_TENANT_LIMIT: tenant_q <= pwdata[6:0];
        REG_ALLOW_GROWTH: allow_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_BASE_SLOTS:   prdata = {25'd0, base_q};
      REG_TENANT_LIMIT: prdata = {25'd0, tenant_q};
      REG_ALLOW_GROWTH: prdata = {31'd0, allow_q};
      default:          prdata = '0;
    endcase
  end

  vsc_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  vsc_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .TAG_BITS  (TAG_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_base_i   (base_q),
    .cfg_tenant_i (tenant_q),
    .cfg_allow_i  (allow_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .res_valid_o  (res_valid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {2'b00, res.tag_valid, res.tag, res.version, res.hit_slot};
  assign m_axis_tuser  = res.status;

endmodule

`default_nettype wire
